// ===== hdl/rbf_pkg.sv =====
package rbf_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int HIST_BITS    = 40;
   localparam int FREQ_BITS    = 21;
   localparam int DECAY_BITS   = 24;
   localparam int NYQ_BITS     = 17;
   localparam int MODE_BITS    = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CORDIC_STEPS = 24;
   localparam int COEF_BITS    = 34;
   localparam int MUL_BITS     = 35;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_MODE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NYQUIST_HZ  = 2'd1;

   localparam logic [MODE_BITS-1:0] MODE_BANDPASS = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOWPASS  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_HIGHPASS = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_BANDPASS;
   localparam logic [NYQ_BITS-1:0]  NYQ_RESET  = 17'd22050;

   localparam logic signed [MUL_BITS-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic [31:0]                HALF_PI_Q30 = 32'd1686629713;
   localparam logic signed [33:0]         CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [MUL_BITS-1:0] DAMP_SCALE  = 35'sd250024595;
   localparam logic signed [33:0]         ONE_Q30     = 34'sd1073741824;

   typedef struct packed {
      logic [FREQ_BITS-1:0]          center_freq;
      logic signed [SAMPLE_BITS-1:0] excitation;
      logic signed [DECAY_BITS-1:0]  decay_time;
      logic                          clear_first;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          clipped;
   } rsp_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         5'd31: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/resonant_biquad_filter_unit.sv =====
// Resonant biquad filter: bandpass, lowpass or highpass, one sample per item.
// Input channel req_*: center frequency, excitation sample, decay time and a
// clear flag; an item is taken when req_valid is high and req_stall is low.
// Result channel rsp_*: one filtered sample and a clip flag per item, held in
// an output register until rsp_stall is low.
// Configuration channel csr_*: filter mode (index 0) and nyquist in hertz
// (index 1); accepted only while no item is in work. Either write forces a
// coefficient recompute on the next item.
// With reused coefficients an item runs prep, the filter MAC and the result
// step; a full recompute runs between prep and the MAC. The recompute takes
// two passes of a one-bit-per-cycle divider and a 24-step CORDIC; its
// multiplies share one 35x35 multiplier with the filter MAC. One item is in
// work at a time; req_stall stays high until the result is loaded into the
// output register, which lets the next item in while a result still waits.
// A stalled result register holds the block in its last step until taken.
// Reset (synchronous) clears the history, restores register defaults and
// marks the coefficients stale.
module resonant_biquad_filter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rbf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rbf_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbf_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]                     csr_data
);
   import rbf_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE      = 17'b00000000000000001,
      S_PREP      = 17'b00000000000000010,
      S_THETA_MUL = 17'b00000000000000100,
      S_THETA_LD  = 17'b00000000000001000,
      S_DIV       = 17'b00000000000010000,
      S_CORDIC_LD = 17'b00000000000100000,
      S_CORDIC    = 17'b00000000001000000,
      S_SC        = 17'b00000000010000000,
      S_DQ1       = 17'b00000000100000000,
      S_DQ2       = 17'b00000001000000000,
      S_DQ3       = 17'b00000010000000000,
      S_HCALC     = 17'b00000100000000000,
      S_M1        = 17'b00001000000000000,
      S_M2        = 17'b00010000000000000,
      S_M3        = 17'b00100000000000000,
      S_MAC       = 17'b01000000000000000,
      S_RES       = 17'b10000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [FREQ_BITS-1:0]          f_ff, f_in;
   logic signed [SAMPLE_BITS-1:0] xn_ff, xn_in;
   logic signed [DECAY_BITS-1:0]  dec_ff, dec_in;
   logic                          clr_ff, clr_in;
   logic [MODE_BITS-1:0]          mode_ff, mode_in;
   logic [NYQ_BITS-1:0]           nyq_ff, nyq_in;
   logic [FREQ_BITS-1:0]          last_f_ff, last_f_in;
   logic signed [DECAY_BITS-1:0]  last_d_ff, last_d_in;
   logic                          stale_ff, stale_in;
   logic signed [COEF_BITS-1:0]   coef_ff [5];
   logic signed [COEF_BITS-1:0]   coef_in [5];
   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [HIST_BITS-1:0]   y1_ff, y1_in, y2_ff, y2_in;
   logic signed [2*MUL_BITS-1:0]  prod_ff, prod_in;
   logic [60:0]                   num_ff, num_in;
   logic [57:0]                   den_ff, den_in;
   logic [57:0]                   rem_ff, rem_in;
   logic [5:0]                    div_cnt_ff, div_cnt_in;
   logic                          div_sel_ff, div_sel_in;
   logic                          fold_ff, fold_in;
   logic signed [33:0]            cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [4:0]                    cstep_ff, cstep_in;
   logic signed [31:0]            c_ff, c_in;
   logic [30:0]                   s_ff, s_in;
   logic [30:0]                   h_ff, h_in;
   logic [15:0]                   nlo_ff, nlo_in;
   logic [56:0]                   dq_ff, dq_in;
   logic [2:0]                    mac_k_ff, mac_k_in;
   logic                          shl_ff, shl_in;
   logic signed [79:0]            acc_ff, acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic signed [MUL_BITS-1:0] mul_a, mul_b;
   logic [NYQ_BITS-1:0]        nyq_eff;
   logic [FREQ_BITS-1:0]       nyq16, fmax, f_clamp;
   logic [58:0]                rem_sh;
   logic                       div_ge;
   logic signed [33:0]         sh_x, sh_y, at_z, cl_c;
   logic signed [2*MUL_BITS-1:0] m_shift;
   logic signed [COEF_BITS-1:0]  m_val;
   logic signed [79:0]         y_wide;
   logic signed [HIST_BITS-1:0] y_sat;
   logic signed [SAMPLE_BITS-1:0] ys;
   logic                       y_clip;
   logic                       rsp_free;

   assign nyq_eff = (nyq_ff == '0) ? NYQ_BITS'(1) : nyq_ff;
   assign nyq16   = {nyq_eff, 4'b0000};
   assign fmax    = nyq16 - FREQ_BITS'(1);

   always_comb begin
      f_clamp = (f_ff == '0) ? FREQ_BITS'(1) : f_ff;
      if (f_clamp > fmax) begin
         f_clamp = fmax;
      end
   end

   assign rem_sh = {rem_ff, num_ff[60]};
   assign div_ge = rem_sh >= {1'b0, den_ff};

   assign sh_x = cx_ff >>> cstep_ff;
   assign sh_y = cy_ff >>> cstep_ff;
   assign at_z = $signed({2'b00, atan_lut(cstep_ff)});

   assign m_shift = prod_ff >>> 30;
   assign m_val   = m_shift[COEF_BITS-1:0];

   assign y_wide = acc_ff >>> 30;
   always_comb begin
      if ((acc_ff[79:69] == '0) || (acc_ff[79:69] == '1)) begin
         y_sat = y_wide[HIST_BITS-1:0];
      end else if (acc_ff[79]) begin
         y_sat = {1'b1, {(HIST_BITS-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(HIST_BITS-1){1'b1}}};
      end
      if ((y_sat[HIST_BITS-1:SAMPLE_BITS-1] == '0) ||
          (y_sat[HIST_BITS-1:SAMPLE_BITS-1] == '1)) begin
         ys     = y_sat[SAMPLE_BITS-1:0];
         y_clip = 1'b0;
      end else if (y_sat[HIST_BITS-1]) begin
         ys     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         y_clip = 1'b1;
      end else begin
         ys     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         y_clip = 1'b1;
      end
   end

   always_comb begin
      if (cx_ff > ONE_Q30) begin
         cl_c = ONE_Q30;
      end else if (cx_ff < -ONE_Q30) begin
         cl_c = -ONE_Q30;
      end else begin
         cl_c = cx_ff;
      end
      if (fold_ff) begin
         cl_c = -cl_c;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_THETA_MUL: begin
            mul_a = $signed({14'b0, f_ff});
            mul_b = PI_Q30;
         end
         S_SC: begin
            mul_a = $signed({14'b0, f_ff});
            mul_b = $signed({{11{dec_ff[DECAY_BITS-1]}}, dec_ff});
         end
         S_DQ1: begin
            mul_a = $signed({7'b0, prod_ff[43:16]});
            mul_b = DAMP_SCALE;
         end
         S_DQ2: begin
            mul_a = $signed({19'b0, nlo_ff});
            mul_b = DAMP_SCALE;
         end
         S_M1: begin
            mul_b = $signed({4'b0, h_ff});
            priority case (mode_ff)
               MODE_BANDPASS: mul_a = $signed({4'b0, s_ff});
               MODE_LOWPASS:  mul_a = 35'(ONE_Q30) - 35'(c_ff);
               default:       mul_a = 35'(ONE_Q30) + 35'(c_ff);
            endcase
         end
         S_M2: begin
            mul_a = 35'(c_ff);
            mul_b = $signed({4'b0, h_ff});
         end
         S_MAC: begin
            unique case (mac_k_ff)
               3'd0: begin
                  mul_a = 35'(coef_ff[0]);
                  mul_b = 35'(xn_ff);
               end
               3'd1: begin
                  mul_a = 35'(coef_ff[1]);
                  mul_b = 35'(x1_ff);
               end
               3'd2: begin
                  mul_a = 35'(coef_ff[2]);
                  mul_b = 35'(x2_ff);
               end
               3'd3: begin
                  mul_a = 35'(coef_ff[3]);
                  mul_b = $signed({15'b0, y1_ff[19:0]});
               end
               3'd4: begin
                  mul_a = 35'(coef_ff[3]);
                  mul_b = 35'($signed(y1_ff[39:20]));
               end
               3'd5: begin
                  mul_a = 35'(coef_ff[4]);
                  mul_b = $signed({15'b0, y2_ff[19:0]});
               end
               3'd6: begin
                  mul_a = 35'(coef_ff[4]);
                  mul_b = 35'($signed(y2_ff[39:20]));
               end
               3'd7: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign rsp_free = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in     = state_ff;
      f_in         = f_ff;
      xn_in        = xn_ff;
      dec_in       = dec_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      nyq_in       = nyq_ff;
      last_f_in    = last_f_ff;
      last_d_in    = last_d_ff;
      stale_in     = stale_ff;
      coef_in      = coef_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      div_sel_in   = div_sel_ff;
      fold_in      = fold_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      cstep_in     = cstep_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      h_in         = h_ff;
      nlo_in       = nlo_ff;
      dq_in        = dq_ff;
      mac_k_in     = mac_k_ff;
      shl_in       = shl_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FILTER_MODE) begin
            mode_in  = csr_data[MODE_BITS-1:0];
            stale_in = 1'b1;
         end else if (csr_index == CSR_NYQUIST_HZ) begin
            nyq_in   = csr_data[NYQ_BITS-1:0];
            stale_in = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               f_in     = req_data.center_freq;
               xn_in    = req_data.excitation;
               dec_in   = req_data.decay_time;
               clr_in   = req_data.clear_first;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            f_in     = f_clamp;
            mac_k_in = '0;
            if (clr_ff) begin
               x1_in = '0;
               x2_in = '0;
               y1_in = '0;
               y2_in = '0;
            end
            if (stale_ff || (f_clamp != last_f_ff) || (dec_ff != last_d_ff)) begin
               last_f_in = f_clamp;
               last_d_in = dec_ff;
               stale_in  = 1'b0;
               if ((dec_ff <= 0) || (mode_ff > MODE_HIGHPASS)) begin
                  coef_in[0] = ONE_Q30;
                  coef_in[1] = '0;
                  coef_in[2] = '0;
                  coef_in[3] = '0;
                  coef_in[4] = '0;
                  state_in   = S_MAC;
               end else begin
                  state_in = S_THETA_MUL;
               end
            end else begin
               state_in = S_MAC;
            end
         end
         S_THETA_MUL: begin
            state_in = S_THETA_LD;
         end
         S_THETA_LD: begin
            num_in     = prod_ff[60:0];
            den_in     = 58'(nyq16);
            rem_in     = '0;
            div_cnt_in = 6'd60;
            div_sel_in = 1'b0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            rem_in     = div_ge ? 58'(rem_sh - {1'b0, den_ff}) : rem_sh[57:0];
            num_in     = {num_ff[59:0], div_ge};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == '0) begin
               state_in = div_sel_ff ? S_HCALC : S_CORDIC_LD;
            end
         end
         S_CORDIC_LD: begin
            fold_in  = num_ff[31:0] > HALF_PI_Q30;
            cz_in    = (num_ff[31:0] > HALF_PI_Q30) ?
                       34'(PI_Q30) - $signed({2'b00, num_ff[31:0]}) :
                       $signed({2'b00, num_ff[31:0]});
            cx_in    = CORDIC_GAIN;
            cy_in    = '0;
            cstep_in = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - sh_y;
               cy_in = cy_ff + sh_x;
               cz_in = cz_ff - at_z;
            end else begin
               cx_in = cx_ff + sh_y;
               cy_in = cy_ff - sh_x;
               cz_in = cz_ff + at_z;
            end
            cstep_in = cstep_ff + 5'd1;
            if (cstep_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = S_SC;
            end
         end
         S_SC: begin
            c_in = cl_c[31:0];
            if (cy_ff < 0) begin
               s_in = '0;
            end else if (cy_ff > ONE_Q30) begin
               s_in = 31'h40000000;
            end else begin
               s_in = cy_ff[30:0];
            end
            state_in = S_DQ1;
         end
         S_DQ1: begin
            nlo_in   = prod_ff[15:0];
            state_in = S_DQ2;
         end
         S_DQ2: begin
            dq_in    = prod_ff[56:0];
            state_in = S_DQ3;
         end
         S_DQ3: begin
            den_in     = 58'(dq_ff) + 58'(prod_ff[43:16]) + 58'(s_ff);
            num_in     = {s_ff, 30'b0};
            rem_in     = '0;
            div_cnt_in = 6'd60;
            div_sel_in = 1'b1;
            state_in   = S_DIV;
         end
         S_HCALC: begin
            h_in     = 31'h40000000 - num_ff[30:0];
            state_in = S_M1;
         end
         S_M1: begin
            state_in = S_M2;
         end
         S_M2: begin
            priority case (mode_ff)
               MODE_BANDPASS: begin
                  coef_in[0] = 34'(prod_ff >>> 31);
                  coef_in[1] = '0;
                  coef_in[2] = -34'(prod_ff >>> 31);
               end
               MODE_LOWPASS: begin
                  coef_in[1] = m_val;
                  coef_in[0] = m_val >>> 1;
                  coef_in[2] = m_val >>> 1;
               end
               default: begin
                  coef_in[1] = -m_val;
                  coef_in[0] = m_val >>> 1;
                  coef_in[2] = m_val >>> 1;
               end
            endcase
            state_in = S_M3;
         end
         S_M3: begin
            coef_in[3] = 34'(prod_ff >>> 29);
            coef_in[4] = ONE_Q30 - $signed({2'b00, h_ff, 1'b0});
            mac_k_in   = '0;
            state_in   = S_MAC;
         end
         S_MAC: begin
            if (mac_k_ff == '0) begin
               acc_in = '0;
            end else if (shl_ff) begin
               acc_in = acc_ff + (80'(prod_ff) <<< 20);
            end else begin
               acc_in = acc_ff + 80'(prod_ff);
            end
            shl_in   = (mac_k_ff == 3'd4) || (mac_k_ff == 3'd6);
            mac_k_in = mac_k_ff + 3'd1;
            if (mac_k_ff == 3'd7) begin
               state_in = S_RES;
            end
         end
         S_RES: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.filtered = ys;
               rsp_data_in.clipped  = y_clip;
               x2_in                = x1_ff;
               x1_in                = xn_ff;
               y2_in                = y1_ff;
               y1_in                = y_sat;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      f_ff        <= f_in;
      xn_ff       <= xn_in;
      dec_ff      <= dec_in;
      clr_ff      <= clr_in;
      coef_ff     <= coef_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      div_sel_ff  <= div_sel_in;
      fold_ff     <= fold_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      cstep_ff    <= cstep_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      h_ff        <= h_in;
      nlo_ff      <= nlo_in;
      dq_ff       <= dq_in;
      mac_k_ff    <= mac_k_in;
      shl_ff      <= shl_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_RESET;
         nyq_ff       <= NYQ_RESET;
         last_f_ff    <= '0;
         last_d_ff    <= '0;
         stale_ff     <= 1'b1;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         nyq_ff       <= nyq_in;
         last_f_ff    <= last_f_in;
         last_d_ff    <= last_d_in;
         stale_ff     <= stale_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_PREP))
      else $error("accepted item did not enter prep");

   a_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.clipped) |->
      ((rsp_data_ff.filtered == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ||
       (rsp_data_ff.filtered == {1'b0, {(SAMPLE_BITS-1){1'b1}}})))
      else $error("clipped result not at full scale");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff <= 6'd60))
      else $error("divider count out of range");

   a_res_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RES) && rsp_free) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("result not loaded");

endmodule

// ===== verif/tb_resonant_biquad_filter_unit.sv =====
`timescale 1ns / 100ps

module tb_resonant_biquad_filter_unit;
   import rbf_pkg::*;

   localparam int WATCHDOG_CYCLES = 20000;
   localparam int SETTLE_CYCLES = 400;

   class filter_scoreboard;
      logic [1:0] mode;
      logic [16:0] nyq;
      longint coef[5];
      longint xh[2];
      longint yh[2];
      longint prev_freq;
      longint prev_decay;
      bit stale;
      rsp_type pending[$];
      int errors;

      function void clear_state();
         mode = MODE_RESET;
         nyq = NYQ_RESET;
         foreach (coef[i]) coef[i] = 0;
         xh[0] = 0; xh[1] = 0; yh[0] = 0; yh[1] = 0;
         prev_freq = 0;
         prev_decay = 0;
         stale = 1;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         if (idx == CSR_FILTER_MODE) begin
            mode = val[1:0];
            stale = 1;
         end else if (idx == CSR_NYQUIST_HZ) begin
            nyq = val[16:0];
            stale = 1;
         end
      endfunction

      function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      function void recompute(longint f, longint decay, longint nyq16);
         longint theta, x, y, z, s, c, h, a0, a1, a2, nx, ny, m;
         longint unsigned n, dq, e;
         bit fold;
         prev_freq = f;
         prev_decay = decay;
         stale = 0;
         if (decay <= 0 || mode > MODE_HIGHPASS) begin
            coef[0] = 64'sd1 << 30;
            for (int i = 1; i < 5; i++) coef[i] = 0;
            return;
         end
         theta = longint'((longint'(f) * 64'd3373259426) / nyq16);
         fold = theta > 64'sd1686629713;
         z = fold ? 64'sd3373259426 - theta : theta;
         x = 64'sd652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
               nx = x - floor_shift(y, i);
               ny = y + floor_shift(x, i);
               z -= longint'(atan_tab(i));
            end else begin
               nx = x + floor_shift(y, i);
               ny = y - floor_shift(x, i);
               z += longint'(atan_tab(i));
            end
            x = nx;
            y = ny;
         end
         c = x > (64'sd1 << 30) ? (64'sd1 << 30) : (x < -(64'sd1 << 30) ? -(64'sd1 << 30) : x);
         if (fold) c = -c;
         s = y < 0 ? 0 : (y > (64'sd1 << 30) ? (64'sd1 << 30) : y);
         n = longint'(f) * decay;
         dq = (n >> 16) * 64'd250024595 + (((n & 64'hFFFF) * 64'd250024595) >> 16);
         e = (longint'(s) << 30) / (dq + s);
         h = (64'sd1 << 30) - longint'(e);
         if (mode == MODE_BANDPASS) begin
            a0 = (s * h) >>> 31;
            a1 = 0;
            a2 = -a0;
         end else if (mode == MODE_LOWPASS) begin
            a1 = (((64'sd1 << 30) - c) * h) >>> 30;
            a0 = a1 >>> 1;
            a2 = a0;
         end else begin
            m = (((64'sd1 << 30) + c) * h) >>> 30;
            a1 = -m;
            a0 = m >>> 1;
            a2 = a0;
         end
         coef[0] = a0;
         coef[1] = a1;
         coef[2] = a2;
         coef[3] = (c * h) >>> 29;
         coef[4] = (64'sd1 << 30) - 2 * h;
      endfunction

      function logic [31:0] atan_tab(int i);
         return atan_lut(i[4:0]);
      endfunction

      function void note_sample(req_type r);
         longint f, xn, decay, nyq16, y, ys;
         logic signed [127:0] acc, sh;
         logic signed [127:0] hmax;
         bit clip;
         rsp_type exp_rsp;
         f = r.center_freq;
         xn = r.excitation;
         decay = r.decay_time;
         nyq16 = (nyq == 0 ? 1 : nyq) * 16;
         hmax = (128'sd1 <<< 39) - 1;
         if (r.clear_first) begin
            xh[0] = 0; xh[1] = 0; yh[0] = 0; yh[1] = 0;
         end
         if (f < 1) f = 1;
         if (f > nyq16 - 1) f = nyq16 - 1;
         if (stale || f != prev_freq || decay != prev_decay)
            recompute(f, decay, nyq16);
         acc = 128'(coef[0]) * 128'(xn) + 128'(coef[1]) * 128'(xh[0])
             + 128'(coef[2]) * 128'(xh[1]) + 128'(coef[3]) * 128'(yh[0])
             + 128'(coef[4]) * 128'(yh[1]);
         sh = acc >>> 30;
         if (sh > hmax) sh = hmax;
         if (sh < -hmax - 1) sh = -hmax - 1;
         y = longint'(sh);
         ys = y;
         clip = 0;
         if (ys > 64'sd8388607) begin
            ys = 64'sd8388607;
            clip = 1;
         end else if (ys < -64'sd8388608) begin
            ys = -64'sd8388608;
            clip = 1;
         end
         xh[1] = xh[0];
         xh[0] = xn;
         yh[1] = yh[0];
         yh[0] = y;
         exp_rsp.filtered = ys[23:0];
         exp_rsp.clipped = clip;
         pending.push_back(exp_rsp);
      endfunction

      function void check_sample(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected sample filtered=%0d clipped=%0b", $time,
                     got.filtered, got.clipped);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.filtered !== want.filtered) begin
            $display("%0t: filtered expected %0d actual %0d", $time, want.filtered,
                     got.filtered);
            errors++;
         end
         if (got.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
                     got.clipped);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   filter_scoreboard board = new();
   bit quiet_phase = 0;
   bit hold_rsp = 0;
   int idle_count = 0;
   bit timed_out = 0;

   resonant_biquad_filter_unit uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_sample(req_data);
         if (rsp_valid && !rsp_stall) board.check_sample(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_count >= WATCHDOG_CYCLES && !timed_out) begin
         timed_out = 1;
         $display("tb_resonant_biquad_filter_unit: done, errors");
         $finish;
      end
   end

   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (600) @(negedge clock);
            hold_rsp = 0;
            rsp_stall <= 0;
            @(negedge clock);
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_stall <= 1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 0;
            @(negedge clock);
         end else begin
            @(negedge clock);
         end
      end
   end

   task automatic send_sample(req_type r);
      int gap;
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type make_sample(bit shaped);
      req_type r;
      r.excitation = 24'($urandom);
      r.clear_first = ($urandom_range(0, 19) == 0);
      if (shaped) begin
         r.center_freq = 21'($urandom_range(1, 16 * board.nyq + 100));
         r.decay_time = $urandom_range(0, 9) == 0 ? 24'(-$urandom_range(0, 100))
                        : 24'($urandom_range(1, 16000));
      end else begin
         r.center_freq = 21'($urandom);
         r.decay_time = 24'($urandom);
      end
      return r;
   endfunction

   initial begin
      req_type r;
      req_type held;
      int modes[3] = '{MODE_BANDPASS, MODE_LOWPASS, MODE_HIGHPASS};
      int nyqs[4] = '{4000, 96000, 22050, 48000};
      board.clear_state();
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      r = '0;
      send_sample(r);
      r.center_freq = '1; r.excitation = 24'sh7FFFFF; r.decay_time = 24'sh7FFFFF;
      send_sample(r);
      r.excitation = 24'sh800000;
      send_sample(r);
      r.decay_time = 24'sh800000;
      send_sample(r);
      r.decay_time = '0; r.clear_first = 1;
      send_sample(r);
      r = '0; r.center_freq = 21'(16 * 22050 / 2); r.decay_time = 24'sd16000;
      r.excitation = 24'sh7FFFFF;
      repeat (6) send_sample(r);
      r.excitation = 24'sh800000;
      repeat (6) send_sample(r);
      write_reg(CSR_FILTER_MODE, 3);
      r.clear_first = 1;
      send_sample(r);
      write_reg(CSR_NYQUIST_HZ, 0);
      send_sample(r);
      write_reg(2'd3, 32'hFFFF_FFFF);
      send_sample(r);

      for (int phase = 0; phase < 12; phase++) begin
         write_reg(CSR_FILTER_MODE, modes[phase % 3]);
         write_reg(CSR_NYQUIST_HZ, nyqs[phase % 4]);
         if (phase == 3) hold_rsp = 1;
         if (phase == 10) quiet_phase = 1;
         held = make_sample(1);
         for (int k = 0; k < 140; k++) begin
            if ($urandom_range(0, 9) == 0) held = make_sample($urandom_range(0, 3) != 0);
            else held.excitation = 24'($urandom);
            held.clear_first = ($urandom_range(0, 29) == 0);
            send_sample(held);
         end
      end

      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.errors == 0)
         $display("tb_resonant_biquad_filter_unit: done, clean");
      else
         $display("tb_resonant_biquad_filter_unit: done, errors");
      $finish;
   end
endmodule
